FILE: src/crfe_pkg.sv
// Package for the clipped rectangle fill engine: sizes, codes, item types and
// the queue entry passed from the front end to the back end. No dependencies.
`default_nettype none

package crfe_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CmpW   = CoordW + 1;
  localparam int unsigned RegW   = 9;
  localparam int unsigned ColorW = 8;

  localparam int unsigned SizeWRaw =
      ($clog2(MaxWidth + 1) > $clog2(MaxHeight + 1)) ?
      $clog2(MaxWidth + 1) : $clog2(MaxHeight + 1);
  localparam int unsigned SizeW  = (SizeWRaw > RegW) ? SizeWRaw : RegW;
  localparam int unsigned XIdxW  = $clog2(MaxWidth);
  localparam int unsigned YIdxW  = $clog2(MaxHeight);
  localparam int unsigned Depth  = MaxWidth * MaxHeight;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned ProdW  = YIdxW + SizeW;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic CmdFill = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_DROPPED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_READ   = 2'd1,
    KIND_REPORT = 2'd2
  } kind_e;

  typedef struct packed {
    logic                     command;
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] y1;
    logic [ColorW-1:0]        red;
    logic [ColorW-1:0]        green;
    logic [ColorW-1:0]        blue;
    logic                     clip;
  } cmd_t;

  typedef struct packed {
    logic [ColorW-1:0] read_red;
    logic [ColorW-1:0] read_green;
    logic [ColorW-1:0] read_blue;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    kind_e               kind;
    status_e             status;
    logic [3*ColorW-1:0] color;
    logic [XIdxW-1:0]    xa;
    logic [XIdxW-1:0]    xb;
    logic [YIdxW-1:0]    ya;
    logic [YIdxW-1:0]    yb;
  } entry_t;

  function automatic logic [SizeW-1:0] eff_size(input logic [RegW-1:0] r,
                                                input int unsigned mx);
    logic [SizeW-1:0] v;
    if (r == '0) begin
      v = SizeW'(1);
    end else if (32'(r) > mx) begin
      v = SizeW'(mx);
    end else begin
      v = SizeW'(r);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/crfe_if.sv
// Valid/ready channel interfaces for command and response items.
// Depends on crfe_pkg for the payload types.
`default_nettype none

interface crfe_cmd_if import crfe_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface crfe_rsp_if import crfe_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: src/crfe_queue.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on crfe_pkg for the entry type and queue sizes.
`default_nettype none

module crfe_queue import crfe_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_data_i,
  output      logic   full_o,
  input  wire logic   pop_i,
  output      logic   valid_o,
  output      entry_t pop_data_o
);

  entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: src/crfe_front.sv
// Front end: accepts command items, orders and clips the bounds against the
// frame and pushes a classified entry into the queue. Depends on crfe_pkg.
`default_nettype none

module crfe_front import crfe_pkg::*; (
  crfe_cmd_if.sink         cmd_i,
  input  wire logic [SizeW-1:0] w_i,
  input  wire logic [SizeW-1:0] h_i,
  input  wire logic        clearing_i,
  input  wire logic        q_full_i,
  output      logic        push_o,
  output      entry_t      push_data_o
);

  typedef logic signed [CmpW-1:0] cmp_t;

  function automatic cmp_t clamp(input cmp_t v, input cmp_t s);
    cmp_t r;
    if (v[CmpW-1]) begin
      r = '0;
    end else if (v >= s) begin
      r = s - cmp_t'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  cmp_t   sx0, sx1, sy0, sy1, xlo, xhi, ylo, yhi, ws, hs;
  cmp_t   cxa, cxb, cya, cyb;
  logic   reject, dropped, empty;
  entry_t ent;

  assign cmd_i.ready = !q_full_i && !clearing_i;
  assign push_o      = cmd_i.valid && cmd_i.ready;
  assign push_data_o = ent;

  always_comb begin
    sx0 = {cmd_i.payload.x0[CoordW-1], cmd_i.payload.x0};
    sx1 = {cmd_i.payload.x1[CoordW-1], cmd_i.payload.x1};
    sy0 = {cmd_i.payload.y0[CoordW-1], cmd_i.payload.y0};
    sy1 = {cmd_i.payload.y1[CoordW-1], cmd_i.payload.y1};
    ws  = $signed(CmpW'(w_i));
    hs  = $signed(CmpW'(h_i));
    xlo = (sx0 > sx1) ? sx1 : sx0;
    xhi = (sx0 > sx1) ? sx0 : sx1;
    ylo = (sy0 > sy1) ? sy1 : sy0;
    yhi = (sy0 > sy1) ? sy0 : sy1;
    cxa = clamp(xlo, ws);
    cxb = clamp(xhi, ws);
    cya = clamp(ylo, hs);
    cyb = clamp(yhi, hs);

    reject = (sx0[CmpW-1] && sx1[CmpW-1]) || (sx0 >= ws && sx1 >= ws) ||
             (sy0[CmpW-1] && sy1[CmpW-1]) || (sy0 >= hs && sy1 >= hs);
    dropped = xlo[CmpW-1] || xhi >= ws || ylo[CmpW-1] || yhi >= hs;
    empty   = xhi[CmpW-1] || xlo >= ws || yhi[CmpW-1] || ylo >= hs;

    ent        = '0;
    ent.kind   = KIND_FILL;
    ent.status = STATUS_DONE;
    ent.color  = {cmd_i.payload.red, cmd_i.payload.green, cmd_i.payload.blue};
    ent.xa     = cxa[XIdxW-1:0];
    ent.xb     = cxb[XIdxW-1:0];
    ent.ya     = cya[YIdxW-1:0];
    ent.yb     = cyb[YIdxW-1:0];

    if (cmd_i.payload.command == CmdRead) begin
      if (sx0[CmpW-1] || sx0 >= ws || sy0[CmpW-1] || sy0 >= hs) begin
        ent.kind   = KIND_REPORT;
        ent.status = STATUS_REJECTED;
      end else begin
        ent.kind = KIND_READ;
        ent.xa   = sx0[XIdxW-1:0];
        ent.ya   = sy0[YIdxW-1:0];
      end
    end else if (cmd_i.payload.clip) begin
      if (reject) begin
        ent.kind   = KIND_REPORT;
        ent.status = STATUS_REJECTED;
      end
    end else begin
      ent.status = dropped ? STATUS_DROPPED : STATUS_DONE;
      if (empty) begin
        ent.kind = KIND_REPORT;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/crfe_back.sv
// Back end: clears the pixel store after reset, then writes filled rectangles one pixel per cycle
// (the last one can stall on rsp_o) and serves reads through a registered response. Uses crfe_pkg.
`default_nettype none

module crfe_back import crfe_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SizeW-1:0] w_i,
  input  wire logic             q_valid_i,
  input  wire entry_t           q_data_i,
  output      logic             q_pop_o,
  output      logic             clearing_o,
  crfe_rsp_if.source            rsp_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SETUP  = 6'b000100,
    ST_FILL   = 6'b001000,
    ST_RDREQ  = 6'b010000,
    ST_RDWAIT = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  entry_t              ent_q, ent_d;
  logic [AddrW-1:0]    base_q, base_d;
  logic [XIdxW-1:0]    x_q, x_d;
  logic [YIdxW-1:0]    y_q, y_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  logic                rsp_valid_q, rsp_valid_d;
  rsp_t                rsp_data_q, rsp_data_d;
  logic [ProdW-1:0]    prod;
  logic [3*ColorW-1:0] mem [Depth];
  logic [3*ColorW-1:0] rd_data_q;
  logic [3*ColorW-1:0] mem_wdata;
  logic [AddrW-1:0]    mem_addr;
  logic                mem_we, mem_re;
  logic                out_free, last_px;

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_data_q;
  assign clearing_o    = (state_q == ST_CLEAR);
  assign out_free      = !rsp_valid_q || rsp_o.ready;
  assign prod          = ProdW'(ent_q.ya) * ProdW'(w_i);
  assign last_px       = (x_q == ent_q.xb) && (y_q == ent_q.yb);

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    base_d      = base_q;
    x_d         = x_q;
    y_d         = y_q;
    clr_d       = clr_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_data_d  = rsp_data_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = ent_q.color;
    mem_addr    = base_q + AddrW'(x_q);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        mem_addr  = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ent_d   = q_data_i;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        base_d = prod[AddrW-1:0];
        x_d    = ent_q.xa;
        y_d    = ent_q.ya;
        unique case (ent_q.kind)
          KIND_FILL: state_d = ST_FILL;
          KIND_READ: state_d = ST_RDREQ;
          KIND_REPORT: begin
            if (out_free) begin
              rsp_valid_d = 1'b1;
              rsp_data_d  = '{read_red: '0, read_green: '0, read_blue: '0,
                              status: ent_q.status};
              state_d     = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        if (!last_px || out_free) begin
          mem_we = 1'b1;
          if (last_px) begin
            rsp_valid_d = 1'b1;
            rsp_data_d  = '{read_red: '0, read_green: '0, read_blue: '0,
                            status: ent_q.status};
            state_d     = ST_IDLE;
          end else if (x_q == ent_q.xb) begin
            x_d    = ent_q.xa;
            y_d    = y_q + 1'b1;
            base_d = base_q + AddrW'(w_i);
          end else begin
            x_d = x_q + 1'b1;
          end
        end
      end
      ST_RDREQ: begin
        mem_re  = 1'b1;
        state_d = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = '{read_red: rd_data_q[3*ColorW-1:2*ColorW],
                          read_green: rd_data_q[2*ColorW-1:ColorW],
                          read_blue: rd_data_q[ColorW-1:0],
                          status: STATUS_DONE};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
      x_q         <= x_d;
      y_q         <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    base_q     <= base_d;
    rsp_data_q <= rsp_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

`ifndef SYNTHESIS
  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == ST_IDLE) else $error("entry taken while busy");
  a_fill_x_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> x_q >= ent_q.xa && x_q <= ent_q.xb)
    else $error("column outside rectangle");
  a_fill_y_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> y_q >= ent_q.ya && y_q <= ent_q.yb)
    else $error("row outside rectangle");
  a_no_write_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_o.ready |=> $stable(rsp_data_q) || !rsp_valid_q ||
    $past(state_q) == ST_CLEAR) else $error("pending response overwritten");
`endif

endmodule

`default_nettype wire

FILE: src/clipped_rect_fill_engine_core.sv
// Top level of the clipped rectangle fill engine: configuration registers,
// front end, entry queue and back end. Depends on crfe_pkg and crfe_if.
//
//   channel   direction  handshake          payload
//   cmd_i     in         valid/ready        cmd_t (command, bounds, color, clip)
//   rsp_o     out        valid/ready        rsp_t (read color, status)
//   cfg       in         cfg_we_i strobe    cfg_idx_i, cfg_data_i
//
// After reset the pixel store is cleared one entry per cycle, all MaxWidth*MaxHeight
// entries (65536 at the default size), and cmd_i.ready stays low until it ends.
// A fill writes its clipped area one store write per cycle, the last held until
// rsp_o is free; a read uses request and wait states on the single store port.
// The queue holds two classified items, so the front keeps accepting while a
// response waits on rsp_o.ready.
`default_nettype none

module clipped_rect_fill_engine_core import crfe_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [0:0]      cfg_idx_i,
  input  wire logic [RegW-1:0] cfg_data_i,
  crfe_cmd_if.sink             cmd_i,
  crfe_rsp_if.source           rsp_o
);

  logic [RegW-1:0]  frame_width_q, frame_width_d;
  logic [RegW-1:0]  frame_height_q, frame_height_d;
  logic [SizeW-1:0] w_eff, h_eff;
  logic             push, q_full, q_pop, q_valid, clearing;
  entry_t           push_data, pop_data;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  frame_width_d  = cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RegW'(256);
      frame_height_q <= RegW'(256);
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  assign w_eff = eff_size(frame_width_q, MaxWidth);
  assign h_eff = eff_size(frame_height_q, MaxHeight);

  crfe_front u_front (
    .cmd_i       (cmd_i),
    .w_i         (w_eff),
    .h_i         (h_eff),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  crfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  crfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .w_i        (w_eff),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the clipped rectangle fill engine: directed and random fill and
// read items are checked against a behavioral frame model kept in the bench.
// Depends on crfe_pkg, crfe_if and clipped_rect_fill_engine_core.

module tb_top;
  import crfe_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 8;
  localparam int SettleCycles = 16;
  localparam int LongHold     = 300;
  localparam int StallLimit   = 300000;
  localparam int PhaseItems   = 110;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [0:0]      cfg_idx_i;
  logic [RegW-1:0] cfg_data_i;

  crfe_cmd_if cmd_if ();
  crfe_rsp_if rsp_if ();

  clipped_rect_fill_engine_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .rsp_o      (rsp_if)
  );

  logic [3*ColorW-1:0] frame_mem [Depth];
  logic [RegW-1:0]     width_reg;
  logic [RegW-1:0]     height_reg;
  rsp_t                pending_rsp [$];
  rsp_t                head_rsp;
  int                  error_count = 0;
  int                  idle_cycles = 0;
  bit                  sender_gaps = 1'b1;
  bit                  sink_stalls = 1'b1;
  bit                  rsp_hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic int saturate_dim(input logic [RegW-1:0] r, input int mx);
    int v;
    v = int'(r);
    if (v < 1) v = 1;
    if (v > mx) v = mx;
    return v;
  endfunction

  function automatic int clamp_dim(input int v, input int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  // Applies one item to the frame copy and returns the response it should give.
  function automatic rsp_t render_command(input cmd_t c);
    rsp_t r;
    int   w, h, xa, xb, ya, yb, t, x, y;
    w  = saturate_dim(width_reg, MaxWidth);
    h  = saturate_dim(height_reg, MaxHeight);
    xa = c.x0;
    xb = c.x1;
    ya = c.y0;
    yb = c.y1;
    r  = '0;
    r.status = STATUS_DONE;
    if (c.command == CmdRead) begin
      if (xa < 0 || xa >= w || ya < 0 || ya >= h) begin
        r.status = STATUS_REJECTED;
      end else begin
        {r.read_red, r.read_green, r.read_blue} = frame_mem[ya * w + xa];
      end
      return r;
    end
    if (c.clip && ((xa < 0 && xb < 0) || (xa >= w && xb >= w) ||
                   (ya < 0 && yb < 0) || (ya >= h && yb >= h))) begin
      r.status = STATUS_REJECTED;
      return r;
    end
    if (xa > xb) begin
      t = xa; xa = xb; xb = t;
    end
    if (ya > yb) begin
      t = ya; ya = yb; yb = t;
    end
    if (!c.clip) begin
      if (xa < 0 || xb >= w || ya < 0 || yb >= h) r.status = STATUS_DROPPED;
      if (xb < 0 || xa >= w || yb < 0 || ya >= h) return r;
    end
    xa = clamp_dim(xa, w);
    xb = clamp_dim(xb, w);
    ya = clamp_dim(ya, h);
    yb = clamp_dim(yb, h);
    for (y = ya; y <= yb; y++) begin
      for (x = xa; x <= xb; x++) begin
        frame_mem[y * w + x] = {c.red, c.green, c.blue};
      end
    end
    return r;
  endfunction

  function automatic cmd_t make_cmd(input logic command, input int xa, input int xb,
                                    input int ya, input int yb,
                                    input logic [3*ColorW-1:0] rgb, input logic clip);
    cmd_t c;
    c.command = command;
    c.x0 = CoordW'(xa);
    c.x1 = CoordW'(xb);
    c.y0 = CoordW'(ya);
    c.y1 = CoordW'(yb);
    {c.red, c.green, c.blue} = rgb;
    c.clip = clip;
    return c;
  endfunction

  function automatic int wild_coord();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // Most bound pairs sit near the frame with a short span; the rest reach far out.
  function automatic void random_bounds(input int n, input bit wild, output int a,
                                        output int b);
    if (wild) begin
      a = wild_coord();
      b = $urandom_range(0, 1) ? wild_coord() : int'($urandom_range(0, n - 1));
    end else begin
      a = int'($urandom_range(0, n + 7)) - 4;
      b = a + int'($urandom_range(0, 12)) - 6;
    end
  endfunction

  function automatic cmd_t random_command();
    int w, h, xa, xb, ya, yb;
    bit wild_x, wild_y;
    w = saturate_dim(width_reg, MaxWidth);
    h = saturate_dim(height_reg, MaxHeight);
    wild_x = ($urandom_range(0, 99) < 12);
    wild_y = !wild_x && ($urandom_range(0, 99) < 12);
    random_bounds(w, wild_x, xa, xb);
    random_bounds(h, wild_y, ya, yb);
    return make_cmd(($urandom_range(0, 99) < 55) ? CmdFill : CmdRead, xa, xb, ya, yb,
                    24'($urandom()), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_command(input cmd_t c);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_rsp.push_back(render_command(c));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Only called once the engine is idle.
  task automatic program_frame(input int w, input int h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_FRAME_WIDTH;
    cfg_data_i <= RegW'(w);
    @(negedge clk_i);
    cfg_idx_i  <= REG_FRAME_HEIGHT;
    cfg_data_i <= RegW'(h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    width_reg  = RegW'(w);
    height_reg = RegW'(h);
  endtask

  task automatic test_cleared_frame();
    send_command(make_cmd(CmdRead, 0, 0, 0, 0, 24'h000000, 1'b0));
    send_command(make_cmd(CmdRead, 255, 0, 255, 0, 24'h000000, 1'b1));
  endtask

  task automatic test_clip_cases();
    send_command(make_cmd(CmdFill, -32768, 32767, 32767, -32768, 24'hff00ff, 1'b1));
    send_command(make_cmd(CmdRead, 17, 0, 200, 0, 24'h000000, 1'b0));
    send_command(make_cmd(CmdFill, -5, -1, 0, 3, 24'hffffff, 1'b1));
    send_command(make_cmd(CmdFill, 256, 300, 0, 3, 24'hffffff, 1'b1));
    send_command(make_cmd(CmdFill, 0, 3, -32768, -32768, 24'hffffff, 1'b1));
    send_command(make_cmd(CmdFill, 0, 3, 32767, 256, 24'hffffff, 1'b1));
    send_command(make_cmd(CmdFill, 300, 250, 2, -3, 24'h00ff00, 1'b1));
    send_command(make_cmd(CmdRead, 255, 0, 0, 0, 24'h000000, 1'b0));
    send_command(make_cmd(CmdFill, 10, 5, 7, 3, 24'h123456, 1'b0));
    send_command(make_cmd(CmdRead, 5, 0, 3, 0, 24'h000000, 1'b0));
    send_command(make_cmd(CmdFill, -2, 3, 258, 254, 24'h010203, 1'b0));
    send_command(make_cmd(CmdRead, 0, 0, 255, 0, 24'h000000, 1'b0));
    send_command(make_cmd(CmdFill, 300, 400, 0, 0, 24'hffffff, 1'b0));
    send_command(make_cmd(CmdFill, -32768, 32767, 100, 100, 24'h807f01, 1'b0));
    send_command(make_cmd(CmdRead, 128, 0, 100, 0, 24'h000000, 1'b0));
  endtask

  task automatic test_read_bounds();
    send_command(make_cmd(CmdRead, -1, 0, 0, 0, 24'hffffff, 1'b0));
    send_command(make_cmd(CmdRead, 256, 0, 5, 0, 24'h000000, 1'b1));
    send_command(make_cmd(CmdRead, 5, 0, 256, 0, 24'h000000, 1'b0));
    send_command(make_cmd(CmdRead, -32768, 0, 32767, 0, 24'h000000, 1'b1));
    send_command(make_cmd(CmdRead, 255, 0, 255, 0, 24'h000000, 1'b0));
  endtask

  task automatic test_frame_sizes();
    int widths  [10] = '{0, 511, 256, 1, 300, 2, 0, 0, 0, 256};
    int heights [10] = '{0, 511, 1, 256, 7, 3, 0, 0, 0, 256};
    int i, n, w, h;
    for (i = 0; i < 10; i++) begin
      w = widths[i];
      h = heights[i];
      if (i >= 6 && i <= 8) begin
        w = $urandom_range(1, 32);
        h = $urandom_range(1, 32);
      end
      wait_drained();
      program_frame(w, h);
      for (n = 0; n < PhaseItems; n++) send_command(random_command());
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    wait_drained();
    program_frame(16, 16);
    sender_gaps  = 1'b0;
    rsp_hold_req = 1'b1;
    for (n = 0; n < 12; n++) send_command(random_command());
    sender_gaps = 1'b1;
  endtask

  task automatic test_back_to_back();
    int n;
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    for (n = 0; n < 60; n++) send_command(random_command());
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_sender_pause();
    int round, n;
    for (round = 0; round < 2; round++) begin
      for (n = 0; n < 30; n++) send_command(random_command());
      wait_drained();
    end
  endtask

  initial begin : rsp_drain
    int stall;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        rsp_hold_req = 1'b0;
      end
      stall = sink_stalls ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response item arrived with no command outstanding");
        error_count++;
      end else begin
        head_rsp = pending_rsp.pop_front();
        if (rsp_if.payload.read_red !== head_rsp.read_red) begin
          $error("read_red: expected %0d, actual %0d", head_rsp.read_red,
                 rsp_if.payload.read_red);
          error_count++;
        end
        if (rsp_if.payload.read_green !== head_rsp.read_green) begin
          $error("read_green: expected %0d, actual %0d", head_rsp.read_green,
                 rsp_if.payload.read_green);
          error_count++;
        end
        if (rsp_if.payload.read_blue !== head_rsp.read_blue) begin
          $error("read_blue: expected %0d, actual %0d", head_rsp.read_blue,
                 rsp_if.payload.read_blue);
          error_count++;
        end
        if (rsp_if.payload.status !== head_rsp.status) begin
          $error("status: expected %0d, actual %0d", head_rsp.status,
                 rsp_if.payload.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Timeout: no item moved for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_FRAME_WIDTH;
    cfg_data_i     = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    width_reg      = RegW'(256);
    height_reg     = RegW'(256);
    foreach (frame_mem[i]) frame_mem[i] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cleared_frame();
    test_clip_cases();
    test_read_bounds();
    test_frame_sizes();
    test_output_backpressure();
    test_back_to_back();
    test_sender_pause();
    wait_drained();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/crfe_pkg.sv
src/crfe_if.sv
src/crfe_queue.sv
src/crfe_front.sv
src/crfe_back.sv
src/clipped_rect_fill_engine_core.sv
tb/tb_top.sv
